### design/hpt_pkg.sv
// Shared types and constants for the homogeneous point transform.
`timescale 1ns / 1ps
`default_nettype none
package hpt_pkg;
  localparam int unsigned WordW = 32;

  typedef enum logic {
    OP_WRITE     = 1'b0,
    OP_TRANSFORM = 1'b1
  } opcode_t;

  // Classified item handed from the front part to the back part.
  typedef struct packed {
    opcode_t           op;
    logic [3:0]        index;
    logic [WordW-1:0]  value;
    logic [WordW-1:0]  x;
    logic [WordW-1:0]  y;
    logic [WordW-1:0]  z;
    logic [WordW-1:0]  w;
  } item_t;

  // One result item.
  typedef struct packed {
    logic [WordW-1:0] x;
    logic [WordW-1:0] y;
    logic [WordW-1:0] z;
    logic [WordW-1:0] w;
    logic             zero_weight;
    logic             overflow;
  } result_t;
endpackage
`default_nettype wire

### design/hpt_queue.sv
// Two-entry queue between the front and back parts.
`timescale 1ns / 1ps
`default_nettype none
module hpt_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  hpt_pkg::item_t     push_item,
  output logic               full,
  input  wire logic          pop,
  output hpt_pkg::item_t     pop_item,
  output logic               not_empty
);
  import hpt_pkg::*;

  item_t      mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full      = cnt_r == 2'd2;
  assign not_empty = cnt_r != 2'd0;
  assign pop_item  = mem_r[rp_r];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_item;
  end
endmodule
`default_nettype wire

### design/hpt_divider.sv
// Radix-2 restoring divider for normalization: (num << FRAC_BITS) / den, truncated.
`timescale 1ns / 1ps
`default_nettype none
module hpt_divider #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] num,
  input  wire logic [31:0] den,
  output logic             done,
  output logic [31:0]      quot,
  output logic             sat
);
  localparam int unsigned NW = 32 + FRAC_BITS;
  localparam int unsigned CW = $clog2(NW + 1);

  logic [NW-1:0] dvd_r;
  logic [NW-1:0] q_r;
  logic [32:0]   rem_r;
  logic [31:0]   dmag_r;
  logic          neg_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic [33:0]   trial;
  logic [32:0]   shifted;
  logic [NW:0]   sq;

  assign shifted = {rem_r[31:0], dvd_r[NW-1]};
  assign trial   = {1'b0, shifted} - {2'b0, dmag_r};

  // Iterate one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NW);
        dvd_r  <= {(num[31] ? (~num + 32'd1) : num), {FRAC_BITS{1'b0}}};
        dmag_r <= den[31] ? (~den + 32'd1) : den;
        neg_r  <= num[31] ^ den[31];
        rem_r  <= '0;
        q_r    <= '0;
      end else if (busy_r) begin
        dvd_r <= dvd_r << 1;
        if (!trial[33]) begin
          rem_r <= trial[32:0];
          q_r   <= {q_r[NW-2:0], 1'b1};
        end else begin
          rem_r <= shifted;
          q_r   <= {q_r[NW-2:0], 1'b0};
        end
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  // Sign and saturation of the magnitude quotient.
  always_comb begin
    sq = neg_r ? (~{1'b0, q_r} + 1'b1) : {1'b0, q_r};
    if (!neg_r && q_r > NW'(32'h7FFF_FFFF)) begin
      quot = 32'h7FFF_FFFF;
      sat  = 1'b1;
    end else if (neg_r && q_r > NW'(33'h8000_0000)) begin
      quot = 32'h8000_0000;
      sat  = 1'b1;
    end else begin
      quot = sq[31:0];
      sat  = 1'b0;
    end
  end
endmodule
`default_nettype wire

### design/hpt_engine.sv
// Back part: matrix store, row products one term at a time, normalization and output register.
`timescale 1ns / 1ps
`default_nettype none
module hpt_engine #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          normalize,
  input  wire logic          item_valid,
  input  hpt_pkg::item_t     item,
  output logic               item_pop,
  output logic               res_valid,
  output hpt_pkg::result_t   res,
  input  wire logic          res_ready
);
  import hpt_pkg::*;

  localparam int unsigned AW = 72;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_ACC, S_DIV_START, S_DIV_WAIT, S_OUT
  } state_t;

  state_t       state_r;
  logic [31:0]  mat_r [16];
  item_t        cur_r;
  logic [1:0]   row_r, col_r;
  logic signed [63:0] prod_r;
  logic signed [AW-1:0] acc_r;
  logic [31:0]  comp_r [4];
  logic         ovf_r;
  logic         zw_r;
  logic [1:0]   dix_r;
  logic         mul_last_r;
  logic signed [31:0] mval, pval;
  logic signed [AW-1:0] rnd, sum_nxt;
  logic [31:0]  sat_val;
  logic         sat_ovf;
  logic         div_start, div_done, div_sat;
  logic [31:0]  div_q;

  // Operand select for the shared multiplier.
  always_comb begin
    mval = mat_r[{row_r, col_r}];
    unique case (col_r)
      2'd0: pval = cur_r.x;
      2'd1: pval = cur_r.y;
      2'd2: pval = cur_r.z;
      default: pval = cur_r.w;
    endcase
  end

  // Round to nearest, ties up, then saturate the row sum.
  always_comb begin
    sum_nxt = acc_r + AW'(prod_r);
    rnd     = (sum_nxt + (AW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    sat_ovf = 1'b0;
    sat_val = rnd[31:0];
    if (rnd > AW'(32'sh7FFF_FFFF)) begin
      sat_val = 32'h7FFF_FFFF;
      sat_ovf = 1'b1;
    end else if (rnd < -AW'(64'sh8000_0000)) begin
      sat_val = 32'h8000_0000;
      sat_ovf = 1'b1;
    end
  end

  assign div_start = state_r == S_DIV_START;
  assign item_pop  = state_r == S_IDLE && item_valid;
  assign res_valid = state_r == S_OUT;
  assign res = '{x: comp_r[0], y: comp_r[1], z: comp_r[2], w: comp_r[3],
                 zero_weight: zw_r, overflow: ovf_r};

  hpt_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .num(comp_r[dix_r]), .den(comp_r[3]),
    .done(div_done), .quot(div_q), .sat(div_sat)
  );

  // Sequencer: a product state and an accumulate state per term, then optional division.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      for (int i = 0; i < 16; i++)
        mat_r[i] <= (i % 5 == 0) ? (32'd1 << FRAC_BITS) : 32'd0;
      zw_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: if (item_valid) begin
          if (item.op == OP_WRITE) begin
            mat_r[item.index] <= item.value;
          end else begin
            cur_r   <= item;
            row_r   <= 2'd0;
            col_r   <= 2'd0;
            acc_r   <= '0;
            ovf_r   <= 1'b0;
            zw_r    <= 1'b0;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          prod_r     <= 64'(mval) * 64'(pval);
          mul_last_r <= col_r == 2'd3;
          col_r      <= col_r + 2'd1;
          state_r    <= S_ACC;
        end
        S_ACC: begin
          if (mul_last_r) begin
            comp_r[row_r] <= sat_val;
            ovf_r <= ovf_r | sat_ovf;
            acc_r <= '0;
            row_r <= row_r + 2'd1;
            if (row_r == 2'd3) begin
              if (!normalize) begin
                state_r <= S_OUT;
              end else if (sat_val == 32'd0) begin
                for (int i = 0; i < 4; i++) comp_r[i] <= '0;
                ovf_r   <= 1'b0;
                zw_r    <= 1'b1;
                state_r <= S_OUT;
              end else begin
                dix_r   <= 2'd0;
                state_r <= S_DIV_START;
              end
            end else begin
              state_r <= S_MUL;
            end
          end else begin
            acc_r   <= sum_nxt;
            state_r <= S_MUL;
          end
        end
        S_DIV_START: state_r <= S_DIV_WAIT;
        S_DIV_WAIT: if (div_done) begin
          if (dix_r == 2'd3) begin
            // Hold the divisor until all components are done.
            comp_r[3] <= div_q;
            state_r   <= S_OUT;
          end else begin
            comp_r[dix_r] <= div_q;
            dix_r   <= dix_r + 2'd1;
            state_r <= S_DIV_START;
          end
          ovf_r <= ovf_r | div_sat;
        end
        S_OUT: if (res_ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

### design/homogeneous_point_transform.sv
// Top level of the homogeneous 4x4 point transform.
//
// Input channel in_*: in_tuser carries the opcode (0 writes one matrix entry,
// 1 transforms a point); in_tdata carries entry_index, entry_value and the point.
// Output channel out_*: one transfer per transform item with the transformed
// point and the zero_weight and overflow flags in out_tuser.
// cfg_we/cfg_wdata set the normalize bit; write it only while idle.
// A write item is absorbed by the engine in its idle state. A transform is
// picked up in the idle state, then the four rows are formed on one shared
// 32x32 multiplier, with a product and an accumulate state per term, before
// out_tvalid rises; the engine takes no new item until the result is accepted.
// With normalization on and a nonzero weight, four divisions on the bit-serial
// divider follow, one per component, before out_tvalid rises.
// A two-entry queue lets the input take items while the engine works.
// Reset loads the identity matrix and clears normalize. When the receiver
// stalls the result holds on out_tdata and the queue fills, then in_tready drops.
`timescale 1ns / 1ps
`default_nettype none
module homogeneous_point_transform #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_we,
  input  wire logic          cfg_wdata,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  // entry_index[3:0], entry_value[35:4], x_in[67:36], y_in[99:68], z_in[131:100],
  // w_in[163:132], zero fill to 168
  input  wire logic [167:0]  in_tdata,
  // opcode
  input  wire logic          in_tuser,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  // x_out[31:0], y_out[63:32], z_out[95:64], w_out[127:96]
  output logic [127:0]       out_tdata,
  // zero_weight[0], overflow[1]
  output logic [1:0]         out_tuser
);
  import hpt_pkg::*;

  logic    normalize_r;
  logic    q_full, q_pop, q_ne;
  item_t   q_in, q_out;
  result_t res;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) normalize_r <= 1'b0;
    else if (cfg_we) normalize_r <= cfg_wdata;
  end

  // Front part: unpack the transfer into a classified item.
  assign q_in = '{op: opcode_t'(in_tuser), index: in_tdata[3:0],
                  value: in_tdata[35:4], x: in_tdata[67:36], y: in_tdata[99:68],
                  z: in_tdata[131:100], w: in_tdata[163:132]};
  assign in_tready = !q_full;

  hpt_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(in_tvalid && !q_full), .push_item(q_in),
    .full(q_full), .pop(q_pop), .pop_item(q_out), .not_empty(q_ne)
  );

  hpt_engine #(.FRAC_BITS(FRAC_BITS)) u_engine (
    .clk(clk), .rst_n(rst_n), .normalize(normalize_r),
    .item_valid(q_ne), .item(q_out), .item_pop(q_pop),
    .res_valid(out_tvalid), .res(res), .res_ready(out_tready)
  );

  assign out_tdata = {res.w, res.z, res.y, res.x};
  assign out_tuser = {res.overflow, res.zero_weight};
endmodule
`default_nettype wire
